// File: rtl/core/nas_pkg.sv
// ----------------------------------------------------------------------------
// nas_pkg
// Shared types and constants for the neighbour average smoother.
// ----------------------------------------------------------------------------
package nas_pkg;

    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef logic [7:0] pixel_t;

    // Operation codes of an input request.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [10:0] WIDTH_RESET  = 11'd256;
    localparam logic [12:0] HEIGHT_RESET = 13'd256;

    typedef struct packed {
        logic   operation;
        pixel_t pixel_in;
    } in_t;

    typedef struct packed {
        pixel_t pixel_out;
        logic   frame_end;
    } out_t;

    // Position of the output pixel relative to the frame border.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } edge_flags_t;

    // 3x3 window: 0..2 upper row, 3..5 middle row, 6..8 lower row.
    typedef pixel_t [8:0] window_t;

endpackage

// File: rtl/core/neighbour_average_smoother.sv
// ----------------------------------------------------------------------------
// neighbour_average_smoother
// 3x3 neighbour average of an 8-bit gray raster stream with two line buffers.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle on both channels while the output register
//   is free; results held in stage B and m_data by a low m_ready stall s_ready.
// Line buffer read into stage B, then window update and average into m_data.
// Results trail the source by frame_width + 1 requests (row plus one pixel).
// Reset (aresetn low, synchronous): counters, window and configuration return
//   to defaults; line buffer contents are left as they are.
module neighbour_average_smoother #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  nas_pkg::in_t                        s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output nas_pkg::out_t                       m_data,

    input  logic                                cfg_we,
    input  logic [nas_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nas_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import nas_pkg::*;

    localparam int unsigned CW  = $clog2(MAX_WIDTH);   // column index bits
    localparam int unsigned RW  = $clog2(MAX_HEIGHT);  // output row bits
    localparam int unsigned WVW = CW + 1;              // width value bits
    localparam int unsigned HVW = RW + 1;              // height value bits

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        mode_reg;
    logic [10:0] frame_width_reg;
    logic [12:0] frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= 1'b0;
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODE:   mode_reg         <= cfg_wdata[0];
                CFG_WIDTH:  frame_width_reg  <= cfg_wdata[10:0];
                CFG_HEIGHT: frame_height_reg <= cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // Frame size in use: clamped to [2, MAX]
    logic [WVW-1:0] w_use;
    logic [HVW-1:0] h_use;

    always_comb begin
        if (frame_width_reg < 11'd2) begin
            w_use = WVW'(2);
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            w_use = WVW'(MAX_WIDTH);
        end else begin
            w_use = WVW'(frame_width_reg);
        end
        if (frame_height_reg < 13'd2) begin
            h_use = HVW'(2);
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            h_use = HVW'(MAX_HEIGHT);
        end else begin
            h_use = HVW'(frame_height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage A: position bookkeeping at acceptance
    // ------------------------------------------------------------------
    logic          s_accept;
    pixel_t        pix_a;
    logic          emit_a;
    logic          last_a;
    edge_flags_t   flags_a;

    // input row only matters as 0, 1 or "2 and beyond": saturates at 2
    logic [CW-1:0] in_col_reg,  in_col_next;
    logic [1:0]    in_row_reg,  in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    assign s_accept = s_valid && s_ready;
    assign pix_a    = (s_data.operation == OP_DRAIN) ? '0 : s_data.pixel_in;

    assign emit_a = (in_row_reg >= 2'd2) ||
                    ((in_row_reg == 2'd1) && (in_col_reg != '0));

    assign flags_a.top    = (out_row_reg == '0);
    assign flags_a.bottom = ({1'b0, out_row_reg} >= h_use - HVW'(1));
    assign flags_a.left   = (out_col_reg == '0);
    assign flags_a.right  = ({1'b0, out_col_reg} >= w_use - WVW'(1));
    assign last_a         = flags_a.bottom && flags_a.right;

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (s_accept) begin
            if ({1'b0, in_col_reg} + WVW'(1) >= w_use) begin
                in_col_next = '0;
                if (in_row_reg != 2'd2) begin
                    in_row_next = in_row_reg + 2'd1;
                end
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (emit_a) begin
                if (last_a) begin
                    // frame done: everything restarts at the origin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (flags_a.right) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end else begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffers: read at acceptance, written back when stage B retires.
    // Consecutive requests hitting the same column (only possible around a
    // frame restart) take the value in flight through the bypass.
    // ------------------------------------------------------------------
    pixel_t upper_line_mem [MAX_WIDTH];
    pixel_t lower_line_mem [MAX_WIDTH];

    pixel_t        upper_rd_reg, lower_rd_reg;
    pixel_t        upper_fwd_reg, lower_fwd_reg;
    logic          fwd_reg;

    logic          b_valid_reg;
    logic          b_emit_reg;
    logic          b_last_reg;
    edge_flags_t   b_flags_reg;
    logic [CW-1:0] b_col_reg;
    pixel_t        b_pix_reg;
    logic          b_go;

    pixel_t        above2, above1;

    assign above2 = fwd_reg ? upper_fwd_reg : upper_rd_reg;
    assign above1 = fwd_reg ? lower_fwd_reg : lower_rd_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            upper_rd_reg <= upper_line_mem[in_col_reg];
            lower_rd_reg <= lower_line_mem[in_col_reg];
        end
        if (b_go) begin
            upper_line_mem[b_col_reg] <= above1;
            lower_line_mem[b_col_reg] <= b_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: window shift, write-back and average
    // ------------------------------------------------------------------
    // B retires when it has no result or the output register frees up.
    assign b_go    = b_valid_reg && (!b_emit_reg || !m_valid || m_ready);
    assign s_ready = !b_valid_reg || b_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_accept) begin
            b_valid_reg <= 1'b1;
        end else if (b_go) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            b_emit_reg    <= emit_a;
            b_last_reg    <= last_a;
            b_flags_reg   <= flags_a;
            b_col_reg     <= in_col_reg;
            b_pix_reg     <= pix_a;
            // accepting with B full implies B retires on this same edge
            fwd_reg       <= b_valid_reg && (b_col_reg == in_col_reg);
            upper_fwd_reg <= above1;
            lower_fwd_reg <= b_pix_reg;
        end
    end

    window_t window_reg, window_next;

    always_comb begin
        window_next    = window_reg;
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[2] = above2;
        window_next[3] = window_reg[4];
        window_next[4] = window_reg[5];
        window_next[5] = above1;
        window_next[6] = window_reg[7];
        window_next[7] = window_reg[8];
        window_next[8] = b_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (b_go) begin
            window_reg <= window_next;
        end
    end

    pixel_t avg_b;

    nas_average u_average (
        .win   (window_next),
        .flags (b_flags_reg),
        .mode  (mode_reg),
        .avg   (avg_b)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic m_valid_reg;
    out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_go && b_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_go && b_emit_reg) begin
            m_data_reg.pixel_out <= avg_b;
            m_data_reg.frame_end <= b_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // Input stalls only when both B and the output register hold results.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (b_valid_reg && b_emit_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    // The frame-ending request returns every counter to the origin.
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && emit_a && last_a) |=>
            (in_col_reg == '0 && in_row_reg == 2'd0 &&
             out_col_reg == '0 && out_row_reg == '0))
        else $error("counters not cleared after frame end");

    // Bypass is armed for a request that follows another in B on the same column.
    a_fwd_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && b_valid_reg && (b_col_reg == in_col_reg)) |=> fwd_reg)
        else $error("line buffer bypass missed");

    // Frame end is only flagged with a bottom-right position.
    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_last_reg) |-> (b_flags_reg.bottom && b_flags_reg.right))
        else $error("frame end off the last pixel");
`endif

endmodule

// File: rtl/core/nas_average.sv
// ----------------------------------------------------------------------------
// nas_average
// Neighbour sum and truncating average for one window position.
// ----------------------------------------------------------------------------
module nas_average (
    input  nas_pkg::window_t     win,
    input  nas_pkg::edge_flags_t flags,
    input  logic                 mode,
    output nas_pkg::pixel_t      avg
);
    import nas_pkg::*;

    pixel_t      ul, u, ur, l, r, dl, d, dr;
    pixel_t      lh, rh;
    logic [10:0] sum;

    assign ul = win[0];
    assign u  = win[1];
    assign ur = win[2];
    assign l  = win[3];
    assign r  = win[5];
    assign dl = win[6];
    assign d  = win[7];
    assign dr = win[8];

    // missing horizontal neighbour mirrors the one that exists
    assign lh = flags.left  ? r : l;
    assign rh = flags.right ? l : r;

    always_comb begin
        sum = '0;
        avg = '0;
        if (flags.top) begin
            if (flags.left) begin
                sum = 11'(r) + 11'(d);
                avg = 8'(sum >> 1);
            end else begin
                sum = 11'(l) + 11'(rh) + 11'(d) + 11'(dl);
                avg = 8'(sum >> 2);
            end
        end else if (flags.bottom) begin
            if (flags.right) begin
                sum = 11'(l) + 11'(u);
                avg = 8'(sum >> 1);
            end else begin
                sum = 11'(lh) + 11'(r) + 11'(u) + 11'(ur);
                avg = 8'(sum >> 2);
            end
        end else if (!mode || flags.left || flags.right) begin
            sum = 11'(lh) + 11'(rh) + 11'(u) + 11'(d);
            avg = 8'(sum >> 2);
        end else begin
            sum = ((11'(ul) + 11'(u)) + (11'(ur) + 11'(l)))
                + ((11'(r) + 11'(dl)) + (11'(d) + 11'(dr)));
            avg = 8'(sum >> 3);
        end
    end

endmodule
